[hdl/voxel_line_boundary_faces_defines.svh]
// Assertion macros shared by the voxel line boundary faces modules.
// Depends on nothing; expects i_clk and i_rst_n in the including module.
`ifndef VOXEL_LINE_BOUNDARY_FACES_DEFINES_SVH
`define VOXEL_LINE_BOUNDARY_FACES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VLBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define VLBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/vlbf_pkg.sv]
// Shared widths, codes and controller/datapath interface types for the
// voxel line boundary faces block. No dependencies.
package vlbf_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 8;
    localparam int PLANE_W   = 9;
    localparam int SHADE_W   = 8;
    localparam int COUNT_W   = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = SAMPLE_W + SHADE_W;
    localparam int DSTEP_W   = 3;

    localparam logic [SHADE_W-1:0] SHADE_FULL = 8'd255;

    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXIT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MAX  = 2'd3;

    typedef struct packed {
        logic accept;    // latch the input word
        logic load;      // set up divider and compare flags
        logic div_step;  // one restoring divide step
        logic decide;    // update state, load first face
        logic advance;   // output taken, load queued closing face
    } t_cmd;

    typedef struct packed {
        logic div_last;    // this divide step is the last one
        logic face_any;    // the decision yields at least one face
        logic close_pend;  // a closing face waits behind the current one
    } t_status;

endpackage

[hdl/vlbf_ctrl.sv]
// Sequencer for the voxel line boundary faces block: accept, load, divide, decide,
// emit. Depends on vlbf_pkg and the defines header.
`include "voxel_line_boundary_faces_defines.svh"

module vlbf_ctrl
    import vlbf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.face_any ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    // a queued closing face follows the one just taken
                    if (i_status.close_pend) begin
                        o_cmd.advance = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `VLBF_ASSERT_NEXT(a_div_to_decide, i_rst_n && r_state == S_DIV && i_status.div_last, r_state == S_DECIDE, "divide did not end in decide")
    `VLBF_ASSERT_NEXT(a_accept_to_load, i_rst_n && o_cmd.accept, r_state == S_LOAD, "accepted word not loaded")
    `VLBF_ASSERT_NOW(a_out_blocks_in, o_out_valid, o_in_stall, "input open while a face is held")

endmodule

[hdl/vlbf_dp.sv]
// Datapath for the voxel line boundary faces block: config registers, shade
// divider, inside tracking, face counter and output register. Uses vlbf_pkg.
`include "voxel_line_boundary_faces_defines.svh"

module vlbf_dp
    import vlbf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [SAMPLE_W-1:0]        i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [POS_W-1:0]           i_line_pos,
    input  logic                       i_line_end,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    output logic [KIND_W-1:0]          o_face_kind,
    output logic [PLANE_W-1:0]         o_face_plane,
    output logic [SHADE_W-1:0]         o_shade,
    output logic [COUNT_W-1:0]         o_face_count,
    output logic                       o_last_result
);

    // configuration
    logic signed [SAMPLE_W-1:0] r_thresh_low;
    logic signed [SAMPLE_W-1:0] r_thresh_high;
    logic signed [SAMPLE_W-1:0] r_window_min;
    logic signed [SAMPLE_W-1:0] r_window_max;

    // latched input word
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [POS_W-1:0]           r_pos;
    logic                       r_end;

    // compare flags and divider
    logic                 r_le_min;
    logic                 r_ge_max;
    logic                 r_in_win;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-2:0]     r_dsh;
    logic [SHADE_W-1:0]   r_quo;
    logic [DSTEP_W-1:0]   r_step;

    // block state
    logic                 r_inside;
    logic [SHADE_W-1:0]   r_prev;
    logic [SHADE_W-1:0]   r_cur;
    logic [COUNT_W-1:0]   r_count;
    logic                 r_close_pend;

    // output register
    logic [KIND_W-1:0]    r_out_kind;
    logic [PLANE_W-1:0]   r_out_plane;
    logic [SHADE_W-1:0]   r_out_shade;
    logic [COUNT_W-1:0]   r_out_count;
    logic                 r_out_last;

    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        den_full;
    logic [SAMPLE_W-1:0]      diff_u;
    logic [NUM_W-1:0]         num;
    logic [NUM_W-1:0]         trial;
    logic                     fits;
    logic [SHADE_W-1:0]       cur;
    logic                     entry;
    logic                     exit_face;
    logic                     inside_mid;
    logic                     close_face;
    logic                     first_face;
    logic [PLANE_W-1:0]       plane_next;
    logic [COUNT_W-1:0]       count_inc;

    assign diff     = {r_sample[SAMPLE_W-1], r_sample}
                    - {r_window_min[SAMPLE_W-1], r_window_min};
    assign den_full = {r_window_max[SAMPLE_W-1], r_window_max}
                    - {r_window_min[SAMPLE_W-1], r_window_min};
    assign diff_u   = diff[SAMPLE_W-1:0];
    // (v - min) * 255 as (d << 8) - d
    assign num      = {diff_u, {SHADE_W{1'b0}}} - {{SHADE_W{1'b0}}, diff_u};

    assign trial = r_rem - {1'b0, r_dsh};
    assign fits  = (r_rem >= {1'b0, r_dsh});

    always_comb begin
        priority if (r_le_min) begin
            cur = '0;
        end else if (r_ge_max) begin
            cur = SHADE_FULL;
        end else begin
            cur = r_quo;
        end
    end

    assign entry      = !r_inside && r_in_win;
    assign exit_face  = r_inside && !r_in_win;
    assign inside_mid = entry || (r_inside && !exit_face);
    assign close_face = r_end && inside_mid;
    assign first_face = entry || exit_face;
    assign plane_next = {1'b0, r_pos} + {{(PLANE_W-1){1'b0}}, 1'b1};
    assign count_inc  = r_count + {{(COUNT_W-1){1'b0}}, 1'b1};

    assign o_status.div_last   = (r_step == '0);
    assign o_status.face_any   = first_face || close_face;
    assign o_status.close_pend = r_close_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh_low  <= '0;
            r_thresh_high <= 16'sd32767;
            r_window_min  <= '0;
            r_window_max  <= 16'sd255;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_THRESH_LOW:  r_thresh_low  <= i_cfg_data;
                REG_THRESH_HIGH: r_thresh_high <= i_cfg_data;
                REG_WINDOW_MIN:  r_window_min  <= i_cfg_data;
                REG_WINDOW_MAX:  r_window_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_pos    <= i_line_pos;
            r_end    <= i_line_end;
        end
        if (i_cmd.load) begin
            r_le_min <= (r_sample <= r_window_min);
            r_ge_max <= (r_sample >= r_window_max);
            r_in_win <= (r_sample >= r_thresh_low) && (r_sample <= r_thresh_high);
            r_rem    <= num;
            r_dsh    <= {den_full[SAMPLE_W-1:0], {(SHADE_W-1){1'b0}}};
            r_quo    <= '0;
            r_step   <= '1;
        end else if (i_cmd.div_step) begin
            if (fits) begin
                r_rem <= trial;
            end
            r_quo  <= {r_quo[SHADE_W-2:0], fits};
            r_dsh  <= {1'b0, r_dsh[NUM_W-2:1]};
            r_step <= r_step - {{(DSTEP_W-1){1'b0}}, 1'b1};
        end
        if (i_cmd.decide) begin
            r_cur <= cur;
        end
    end

    // inside tracking and face counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_prev       <= '0;
            r_count      <= '0;
            r_close_pend <= 1'b0;
        end else if (i_cmd.decide) begin
            r_inside     <= inside_mid && !r_end;
            r_prev       <= cur;
            r_close_pend <= first_face && close_face;
            if (first_face || close_face) begin
                r_count <= count_inc;
            end
        end else if (i_cmd.advance) begin
            r_close_pend <= 1'b0;
            r_count      <= count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_out_count <= count_inc;
            if (first_face) begin
                r_out_kind  <= entry ? KIND_ENTRY : KIND_EXIT;
                r_out_plane <= plane_next;
                r_out_shade <= entry ? cur : r_prev;
                r_out_last  <= !close_face;
            end else begin
                r_out_kind  <= KIND_CLOSE;
                r_out_plane <= {1'b0, r_pos};
                r_out_shade <= cur;
                r_out_last  <= 1'b1;
            end
        end else if (i_cmd.advance) begin
            r_out_count <= count_inc;
            r_out_kind  <= KIND_CLOSE;
            r_out_plane <= {1'b0, r_pos};
            r_out_shade <= r_cur;
            r_out_last  <= 1'b1;
        end
    end

    assign o_face_kind   = r_out_kind;
    assign o_face_plane  = r_out_plane;
    assign o_shade       = r_out_shade;
    assign o_face_count  = r_out_count;
    assign o_last_result = r_out_last;

    `VLBF_ASSERT_NOW(a_advance_needs_close, i_cmd.advance, r_close_pend, "advance without queued closing face")
    `VLBF_ASSERT_NEXT(a_count_step, i_rst_n && i_cmd.decide && o_status.face_any, r_count == $past(r_count) + 32'd1, "face count did not step")
    `VLBF_ASSERT_NEXT(a_pend_not_last, i_rst_n && i_cmd.decide && first_face && close_face, !r_out_last && r_out_kind != KIND_CLOSE, "first of two faces marked last")

endmodule

[hdl/voxel_line_boundary_faces.sv]
// Voxel line boundary faces: emits entry, exit and closing faces for one
// voxel line at a time. Built from vlbf_ctrl and vlbf_dp; uses vlbf_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one voxel word: sample,
//   line_pos, line_end. Voxels arrive in descending order along the line.
//   Output channel (o_out_valid / i_out_stall) carries zero, one or two face
//   words per voxel; o_last_result marks the last face of a voxel.
//   Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data) for the
//   object window and shade window; write it only while the block is idle.
// Sequence:
//   From acceptance to its first face a voxel passes through latch, then
//   forming (v-min)*255 and the compare flags, then the restoring divide
//   (one quotient bit per cycle), then decide. Each face then holds the
//   output until taken. A voxel with no face frees the input once decided;
//   otherwise after its last face is taken.
//   The input stays stalled while a voxel is in work or its faces are held.
// Reset: synchronous active low; clears the inside flag, previous shade,
//   face count and restores register defaults. A stalled face holds steady.
module voxel_line_boundary_faces
    import vlbf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [SAMPLE_W-1:0]        i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [POS_W-1:0]           i_line_pos,
    input  logic                       i_line_end,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [KIND_W-1:0]          o_face_kind,
    output logic [PLANE_W-1:0]         o_face_plane,
    output logic [SHADE_W-1:0]         o_shade,
    output logic [COUNT_W-1:0]         o_face_count,
    output logic                       o_last_result
);

    t_cmd    cmd;
    t_status status;

    vlbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    vlbf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_line_pos    (i_line_pos),
        .i_line_end    (i_line_end),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_face_kind   (o_face_kind),
        .o_face_plane  (o_face_plane),
        .o_shade       (o_shade),
        .o_face_count  (o_face_count),
        .o_last_result (o_last_result)
    );

endmodule

[bench/vlbf_face_checker.sv]
// Face checker for voxel_line_boundary_faces: follows the config port and both
// channels, predicts the faces of every accepted voxel word and compares them.
// Depends on vlbf_pkg.
module vlbf_face_checker
    import vlbf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [SAMPLE_W-1:0]        i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [POS_W-1:0]           i_line_pos,
    input  logic                       i_line_end,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [KIND_W-1:0]          i_face_kind,
    input  logic [PLANE_W-1:0]         i_face_plane,
    input  logic [SHADE_W-1:0]         i_shade,
    input  logic [COUNT_W-1:0]         i_face_count,
    input  logic                       i_last_result,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_faces_seen
);

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PLANE_W-1:0] plane;
        logic [SHADE_W-1:0] shade;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_face;

    t_face faces_due[$];

    logic signed [SAMPLE_W-1:0] obj_lo, obj_hi, grey_lo, grey_hi;
    logic                       inside_obj;
    logic [SHADE_W-1:0]         prior_shade;
    logic [COUNT_W-1:0]         faces_made;
    int                         fails;
    int                         seen;

    function automatic logic [SHADE_W-1:0] grey_level(input int v);
        longint span;
        longint scaled;
        if (v <= int'(grey_lo)) return '0;
        if (v >= int'(grey_hi)) return SHADE_FULL;
        span   = longint'(grey_hi) - longint'(grey_lo);
        scaled = (longint'(v) - longint'(grey_lo)) * 255;
        return SHADE_W'(scaled / span);
    endfunction

    task automatic predict_word(input logic signed [SAMPLE_W-1:0] s,
                                input logic [POS_W-1:0] p, input logic e);
        t_face              made[2];
        int                 n;
        logic [SHADE_W-1:0] cur;
        logic [PLANE_W-1:0] past_plane;
        logic               in_obj;
        n          = 0;
        cur        = grey_level(int'(s));
        in_obj     = (s >= obj_lo) && (s <= obj_hi);
        past_plane = {1'b0, p} + 9'd1;
        if (!inside_obj && in_obj) begin
            faces_made = faces_made + 1;
            made[n]    = {KIND_ENTRY, past_plane, cur, faces_made, 1'b0};
            n++;
            inside_obj = 1'b1;
        end else if (inside_obj && !in_obj) begin
            faces_made = faces_made + 1;
            made[n]    = {KIND_EXIT, past_plane, prior_shade, faces_made, 1'b0};
            n++;
            inside_obj = 1'b0;
        end
        if (e) begin
            if (inside_obj) begin
                faces_made = faces_made + 1;
                made[n]    = {KIND_CLOSE, {1'b0, p}, cur, faces_made, 1'b0};
                n++;
            end
            inside_obj = 1'b0;
        end
        prior_shade = cur;
        if (n > 0) made[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) faces_due.push_back(made[k]);
    endtask

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: face %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_face due;
        if (!i_rst_n) begin
            obj_lo      = 16'sd0;
            obj_hi      = 16'sd32767;
            grey_lo     = 16'sd0;
            grey_hi     = 16'sd255;
            inside_obj  = 1'b0;
            prior_shade = '0;
            faces_made  = '0;
            faces_due.delete();
            fails       = 0;
            seen        = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESH_LOW:  obj_lo  = i_cfg_data;
                    REG_THRESH_HIGH: obj_hi  = i_cfg_data;
                    REG_WINDOW_MIN:  grey_lo = i_cfg_data;
                    REG_WINDOW_MAX:  grey_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_word(i_sample, i_line_pos, i_line_end);
            if (i_out_valid && !i_out_stall) begin
                seen++;
                if (faces_due.size() == 0) begin
                    $display("%0t: face with nothing expected: kind %0d plane %0d count %0d",
                             $time, i_face_kind, i_face_plane, i_face_count);
                    fails++;
                end else begin
                    due = faces_due.pop_front();
                    check_field("kind", due.kind, i_face_kind);
                    check_field("plane", due.plane, i_face_plane);
                    check_field("shade", due.shade, i_shade);
                    check_field("count", due.count, i_face_count);
                    check_field("last", due.last, i_last_result);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= faces_due.size();
        o_faces_seen <= seen;
    end

endmodule

[bench/voxel_line_boundary_faces_tb.sv]
// Testbench top for voxel_line_boundary_faces: drives config writes and voxel
// lines, puts gaps in the input and stalls on the output, and gives the verdict. Uses vlbf_pkg and vlbf_face_checker.
module voxel_line_boundary_faces_tb;
    import vlbf_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT = 20000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_idx = '0;
    logic [SAMPLE_W-1:0]        cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic [POS_W-1:0]           line_pos = '0;
    logic                       line_end = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [KIND_W-1:0]          face_kind;
    logic [PLANE_W-1:0]         face_plane;
    logic [SHADE_W-1:0]         shade;
    logic [COUNT_W-1:0]         face_count;
    logic                       last_result;

    int fail_count;
    int pending;
    int faces_seen;

    int cur_lo = 0, cur_hi = 32767, cur_min = 0, cur_max = 255;
    int words_sent = 0;
    int settings = 1;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    voxel_line_boundary_faces i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_sample(sample), .i_line_pos(line_pos), .i_line_end(line_end),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_face_kind(face_kind), .o_face_plane(face_plane), .o_shade(shade),
        .o_face_count(face_count), .o_last_result(last_result)
    );

    vlbf_face_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_sample(sample), .i_line_pos(line_pos), .i_line_end(line_end),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_face_kind(face_kind), .i_face_plane(face_plane), .i_shade(shade),
        .i_face_count(face_count), .i_last_result(last_result),
        .o_fail_count(fail_count), .o_pending(pending), .o_faces_seen(faces_seen)
    );

    initial begin : watchdog
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int clamp16(input int v);
        if (v < -32768) return -32768;
        if (v > 32767) return 32767;
        return v;
    endfunction

    function automatic int rand16();
        logic signed [15:0] r;
        r = SAMPLE_W'($urandom);
        return int'(r);
    endfunction

    function automatic int pick_sample(input logic want_in);
        int off;
        if (want_in && cur_lo <= cur_hi) begin
            if ($urandom_range(0, 5) == 0) return ($urandom_range(0, 1) != 0) ? cur_lo : cur_hi;
            off = $urandom_range(0, cur_hi - cur_lo);
            return cur_lo + off;
        end
        off = $urandom_range(0, 4);
        case ($urandom_range(0, 5))
            0: return clamp16(cur_lo - 1);
            1: return clamp16(cur_hi + 1);
            2: return clamp16(cur_min + off - 2);
            3: return clamp16(cur_max + off - 2);
            default: return rand16();
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin : out_side
        int n;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 1) == 0) begin
                n = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                n = $urandom_range(1, 30);
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_word(input int s, input logic [POS_W-1:0] p, input logic e);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= SAMPLE_W'(s);
        line_pos <= p;
        line_end <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
    endtask

    // Wait until every face has come out, then let a face-less word finish.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
            waited++;
            if (waited > DRAIN_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= SAMPLE_W'(v);
        @(posedge clk);
    endtask

    task automatic set_windows(input int lo, input int hi, input int gmin, input int gmax);
        write_reg(REG_THRESH_LOW, lo);
        write_reg(REG_THRESH_HIGH, hi);
        write_reg(REG_WINDOW_MIN, gmin);
        write_reg(REG_WINDOW_MAX, gmax);
        cfg_we  <= 1'b0;
        cur_lo  = lo;
        cur_hi  = hi;
        cur_min = gmin;
        cur_max = gmax;
        settings++;
    endtask

    task automatic random_windows();
        int lo, hi, gmin, gmax, off;
        lo = rand16();
        case ($urandom_range(0, 3))
            0: begin off = $urandom_range(0, 300); hi = clamp16(lo + off); end
            1: begin off = $urandom_range(0, 40000); hi = clamp16(lo + off); end
            2: hi = rand16();
            default: begin lo = -32768; hi = 32767; end
        endcase
        gmin = rand16();
        if ($urandom_range(0, 3) == 0) begin
            gmax = rand16();
        end else begin
            off  = $urandom_range(1, 3000);
            gmax = clamp16(gmin + off);
        end
        set_windows(lo, hi, gmin, gmax);
    endtask

    // Mostly whole lines walked downward; some runs of loose words with
    // random positions and ends, so lines also break off or never close.
    task automatic run_random(input int quota);
        int   first, len, n, left;
        logic want_in;
        first   = words_sent;
        want_in = 1'b0;
        while (words_sent - first < quota) begin
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 10);
                // trim the line to what is left of the quota
                left = quota - (words_sent - first);
                if (len > left) len = left;
                for (int p = len - 1; p >= 0; p--) begin
                    if ($urandom_range(0, 3) == 0) want_in = ~want_in;
                    send_word(pick_sample(want_in), POS_W'(p), p == 0);
                end
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    send_word(pick_sample($urandom_range(0, 1) != 0),
                              POS_W'($urandom_range(0, 255)),
                              $urandom_range(0, 1) != 0);
            end
        end
    endtask

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset windows
        send_word(-1, 10, 1'b0);
        send_word(0, 9, 1'b0);
        send_word(300, 8, 1'b1);
        settle();

        set_windows(-100, 1000, -50, 500);
        send_word(-32768, 255, 1'b0);
        send_word(0, 255, 1'b0);
        send_word(500, 254, 1'b0);
        send_word(32767, 253, 1'b0);
        send_word(-50, 252, 1'b1);
        send_word(1000, 200, 1'b0);
        send_word(-101, 199, 1'b1);
        send_word(-100, 0, 1'b1);
        send_word(1000, 5, 1'b0);
        send_word(1001, 4, 1'b0);
        send_word(200, 3, 1'b0);
        send_word(300, 2, 1'b0);
        send_word(400, 1, 1'b0);
        send_word(450, 0, 1'b1);
        settle();

        // empty object window
        set_windows(1000, -1000, 0, 255);
        send_word(0, 7, 1'b0);
        send_word(32767, 6, 1'b1);
        settle();

        // zero-width shade window, every sample inside
        set_windows(-32768, 32767, 0, 0);
        send_word(-1, 3, 1'b0);
        send_word(0, 2, 1'b0);
        send_word(1, 1, 1'b0);
        send_word(-32768, 0, 1'b1);
        settle();

        // inverted shade window
        set_windows(-32768, 32767, 32767, -32768);
        send_word(100, 255, 1'b1);
        settle();

        set_windows(-32768, 32767, -32768, 32767);
        run_random(120);
        settle();

        // long output hold-off while words keep coming; every line makes faces
        set_windows(-32768, 32767, -1000, 1000);
        hold_req = 1'b1;
        run_random(150);
        settle();

        repeat (4) begin
            random_windows();
            run_random(120);
            settle();
        end

        set_windows(500, 500, -32768, 32767);
        run_random(60);
        settle();

        calm = 1'b1;
        random_windows();
        run_random(120);
        settle();

        $display("Covered %0d voxel words over %0d window settings, %0d faces compared.",
                 words_sent, settings, faces_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
